@@ sv/box_filter_window_sum_defines.svh @@
// Assertion macros shared by the box filter window sum block.
`ifndef BOX_FILTER_WINDOW_SUM_DEFINES_SVH
`define BOX_FILTER_WINDOW_SUM_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define BFWS_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequence holds whenever its antecedent holds.
`define BFWS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ sv/bfws_pkg.sv @@
// Types and constants of the box filter window sum block.
package bfws_pkg;

    localparam int MAX_RADIUS = 63;
    localparam int RING_DEPTH = 2 * MAX_RADIUS + 1;
    localparam int SAMPLE_W   = 8;
    localparam int RADIUS_W   = 6;
    localparam int SUM_W      = 15;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [RADIUS_W-1:0] radius_t;
    typedef logic [SUM_W-1:0]    sum_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    // One slot of the shifting window queue.
    typedef struct packed {
        logic    occ;
        sample_t data;
    } cell_t;

    // Commands from the controller to the queue.
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } chain_ctl_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_SHRINK,
        ST_FLUSH
    } bfws_state_t;

endpackage

@@ sv/box_filter_window_sum.sv @@
// Top level of the box filter window sum: control, running total and result register.
// Sums the bytes in a window of radius bytes on either side of each position, clipped
// at the ends of the stream, and gives one result per position. A result appears once
// the byte radius positions later has arrived; the request that carries final_sample
// is followed by min(held bytes, radius) flush results, one per cycle, the last one
// marked by final_result. Ordinary requests are taken one per cycle. After the radius
// is lowered, the next request waits while the shifting slot row drops the bytes that
// no longer fit the window from its head, one per cycle. Results wait in an output
// register; a stall there holds further requests and flush results.
`include "box_filter_window_sum_defines.svh"

module box_filter_window_sum (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  bfws_pkg::radius_t       cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  bfws_pkg::sample_t       sample,
    input  logic                    final_sample,
    output logic                    out_valid,
    input  logic                    out_ready,
    output bfws_pkg::sum_t          window_sum,
    output logic                    final_result
);

    bfws_pkg::bfws_state_t state_reg;
    bfws_pkg::bfws_state_t state_next;
    bfws_pkg::radius_t     radius_reg;
    bfws_pkg::cnt_t        count_reg;
    bfws_pkg::cnt_t        count_next;
    bfws_pkg::sum_t        total_reg;
    bfws_pkg::sum_t        total_next;
    bfws_pkg::cnt_t        keep_reg;
    bfws_pkg::cnt_t        keep_next;
    bfws_pkg::cnt_t        flush_rem_reg;
    bfws_pkg::cnt_t        flush_rem_next;
    bfws_pkg::sample_t     pend_sample_reg;
    bfws_pkg::sample_t     pend_sample_next;
    logic                  pend_final_reg;
    logic                  pend_final_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    bfws_pkg::sum_t        out_sum_reg;
    bfws_pkg::sum_t        out_sum_next;
    logic                  out_final_reg;
    logic                  out_final_next;

    bfws_pkg::chain_ctl_t  ctl;
    bfws_pkg::cell_t       head;
    bfws_pkg::sample_t     push_data;

    bfws_pkg::cnt_t        r_eff;
    bfws_pkg::cnt_t        win_len;
    logic                  out_free;
    logic                  step_go;
    bfws_pkg::sample_t     step_sample;
    logic                  step_final;
    logic                  step_pop;
    bfws_pkg::sum_t        step_total;
    bfws_pkg::cnt_t        step_count;
    bfws_pkg::cnt_t        step_flush;
    logic                  flush_drop;
    bfws_pkg::sum_t        flush_total;
    logic                  flush_books_ok;

    bfws_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .din   (push_data),
        .head  (head)
    );

    always_comb
    begin
        if (bfws_pkg::cnt_t'(radius_reg) > bfws_pkg::cnt_t'(bfws_pkg::MAX_RADIUS))
        begin
            r_eff = bfws_pkg::cnt_t'(bfws_pkg::MAX_RADIUS);
        end
        else
        begin
            r_eff = bfws_pkg::cnt_t'(radius_reg);
        end
        win_len  = (r_eff << 1) | bfws_pkg::cnt_t'(1);
        out_free = !out_valid_reg || out_ready;
    end

    // Next state, queue commands and result selection.
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        total_next       = total_reg;
        keep_next        = keep_reg;
        flush_rem_next   = flush_rem_reg;
        pend_sample_next = pend_sample_reg;
        pend_final_next  = pend_final_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_sum_next     = out_sum_reg;
        out_final_next   = out_final_reg;
        ctl              = '0;
        in_ready         = 1'b0;
        step_go          = 1'b0;
        step_sample      = sample;
        step_final       = final_sample;
        flush_drop       = 1'b0;
        flush_total      = total_reg;

        unique case (state_reg)
            bfws_pkg::ST_RUN:
            begin
                in_ready = out_free;
                if (in_valid && out_free)
                begin
                    if (count_reg > win_len)
                    begin
                        // hold the request until the window has shrunk
                        pend_sample_next = sample;
                        pend_final_next  = final_sample;
                        state_next       = bfws_pkg::ST_SHRINK;
                    end
                    else
                    begin
                        step_go = 1'b1;
                    end
                end
            end
            bfws_pkg::ST_SHRINK:
            begin
                step_sample = pend_sample_reg;
                step_final  = pend_final_reg;
                if (count_reg > win_len)
                begin
                    ctl.pop    = 1'b1;
                    count_next = count_reg - bfws_pkg::cnt_t'(1);
                    total_next = total_reg - bfws_pkg::sum_t'(head.data);
                end
                else if (out_free)
                begin
                    step_go = 1'b1;
                end
            end
            bfws_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    flush_drop  = count_reg > keep_reg;
                    ctl.pop     = flush_drop;
                    flush_total = flush_drop ? total_reg - bfws_pkg::sum_t'(head.data)
                                             : total_reg;
                    out_valid_next = 1'b1;
                    out_sum_next   = flush_total;
                    out_final_next = flush_rem_reg == bfws_pkg::cnt_t'(1);
                    if (flush_rem_reg == bfws_pkg::cnt_t'(1))
                    begin
                        // end of stream: empty the window
                        ctl.clear      = 1'b1;
                        count_next     = '0;
                        total_next     = '0;
                        flush_rem_next = '0;
                        state_next     = bfws_pkg::ST_RUN;
                    end
                    else
                    begin
                        count_next     = flush_drop ? count_reg - bfws_pkg::cnt_t'(1)
                                                    : count_reg;
                        total_next     = flush_total;
                        flush_rem_next = flush_rem_reg - bfws_pkg::cnt_t'(1);
                        keep_next      = keep_reg - bfws_pkg::cnt_t'(1);
                    end
                end
            end
            default:
            begin
                state_next = bfws_pkg::ST_RUN;
            end
        endcase

        // Window full: drop the head as the new byte enters.
        step_pop   = count_reg == win_len;
        step_total = total_reg + bfws_pkg::sum_t'(step_sample)
                   - (step_pop ? bfws_pkg::sum_t'(head.data) : bfws_pkg::sum_t'(0));
        step_count = step_pop ? count_reg : count_reg + bfws_pkg::cnt_t'(1);
        step_flush = (step_count < r_eff) ? step_count : r_eff;

        if (step_go)
        begin
            ctl.push   = 1'b1;
            ctl.pop    = step_pop;
            count_next = step_count;
            total_next = step_total;
            state_next = bfws_pkg::ST_RUN;
            if (step_count >= r_eff + bfws_pkg::cnt_t'(1))
            begin
                out_valid_next = 1'b1;
                out_sum_next   = step_total;
                out_final_next = step_final && (step_flush == '0);
            end
            if (step_final)
            begin
                if (step_flush == '0)
                begin
                    ctl.clear  = 1'b1;
                    count_next = '0;
                    total_next = '0;
                end
                else
                begin
                    flush_rem_next = step_flush;
                    keep_next      = win_len - bfws_pkg::cnt_t'(1);
                    state_next     = bfws_pkg::ST_FLUSH;
                end
            end
        end
    end

    assign push_data = step_sample;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfws_pkg::ST_RUN;
            radius_reg    <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            keep_reg      <= '0;
            flush_rem_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            keep_reg      <= keep_next;
            flush_rem_reg <= flush_rem_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                radius_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_sample_reg <= pend_sample_next;
        pend_final_reg  <= pend_final_next;
        out_sum_reg     <= out_sum_next;
        out_final_reg   <= out_final_next;
    end

    assign out_valid    = out_valid_reg;
    assign window_sum   = out_sum_reg;
    assign final_result = out_final_reg;

    assign flush_books_ok = (flush_rem_reg != '0)
                         && (count_reg <= keep_reg + bfws_pkg::cnt_t'(1));

    `BFWS_ASSERT(a_head_matches_count, head.occ == (count_reg != '0), "head slot disagrees with count")
    `BFWS_ASSERT_IMPL(a_empty_total, count_reg == '0, total_reg == '0, "empty window with nonzero total")
    `BFWS_ASSERT_IMPL(a_flush_bounds, state_reg == bfws_pkg::ST_FLUSH, flush_books_ok, "flush out of range")

endmodule

@@ sv/bfws_cell.sv @@
// One slot of the window queue: holds a byte, shifts toward the head on pop.
module bfws_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bfws_pkg::chain_ctl_t ctl,
    input  bfws_pkg::sample_t    din,
    input  logic                 left_occ,
    input  bfws_pkg::cell_t      right,
    output bfws_pkg::cell_t      cur
);

    logic              occ_reg;
    logic              occ_next;
    bfws_pkg::sample_t data_reg;
    bfws_pkg::sample_t data_next;
    logic              shifted_occ;
    logic              shifted_left;
    logic              load;

    always_comb
    begin
        // occupancy of this slot and of the left neighbor after the shift
        shifted_occ  = ctl.pop ? right.occ : occ_reg;
        shifted_left = ctl.pop ? occ_reg : left_occ;
        // the first free slot after the shift takes the new byte
        load         = ctl.push && !shifted_occ && shifted_left;
        occ_next     = ctl.clear ? 1'b0 : (shifted_occ | load);
        if (load)
        begin
            data_next = din;
        end
        else if (ctl.pop)
        begin
            data_next = right.data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign cur.occ  = occ_reg;
    assign cur.data = data_reg;

endmodule

@@ sv/bfws_chain.sv @@
// Row of window slots; the oldest held byte always sits in the head slot.
module bfws_chain (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bfws_pkg::chain_ctl_t ctl,
    input  bfws_pkg::sample_t    din,
    output bfws_pkg::cell_t      head
);

    bfws_pkg::cell_t slots [bfws_pkg::RING_DEPTH];
    bfws_pkg::cell_t tail_fill;

    assign tail_fill.occ  = 1'b0;
    assign tail_fill.data = '0;

    for (genvar k = 0; k < bfws_pkg::RING_DEPTH; k++)
    begin : g_slot
        logic            left_occ;
        bfws_pkg::cell_t right;

        if (k == 0)
        begin : g_head
            assign left_occ = 1'b1;
        end
        else
        begin : g_body
            assign left_occ = slots[k-1].occ;
        end

        if (k == bfws_pkg::RING_DEPTH - 1)
        begin : g_tail
            assign right = tail_fill;
        end
        else
        begin : g_inner
            assign right = slots[k+1];
        end

        bfws_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .din      (din),
            .left_occ (left_occ),
            .right    (right),
            .cur      (slots[k])
        );
    end

    assign head = slots[0];

endmodule
